// ===== rtl/core/tri_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tri_pkg: shared types for the 2D trilateration pipeline
// Status codes and the flag group that travels down the datapath.
// ---------------------------------------------------------------------------
package tri_pkg;

   localparam int STATUS_WIDTH = 2;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_COINCIDE  = 2'd1,
      STATUS_COLLINEAR = 2'd2,
      STATUS_SAT       = 2'd3
   } tri_status_type;

   // degenerate geometry flags, raised early and carried with the beat
   typedef struct packed {
      logic coincide;
      logic collinear;
   } tri_flags_type;

endpackage
`default_nettype wire

// ===== rtl/core/tri_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tri_if: request and response channels
// Valid/ready channels carrying anchor sets in and positions out.
// ---------------------------------------------------------------------------
interface tri_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] anchor1_x;
   logic signed [COORD_WIDTH-1:0] anchor1_y;
   logic signed [COORD_WIDTH-1:0] anchor2_x;
   logic signed [COORD_WIDTH-1:0] anchor2_y;
   logic signed [COORD_WIDTH-1:0] anchor3_x;
   logic signed [COORD_WIDTH-1:0] anchor3_y;
   logic        [COORD_WIDTH-2:0] range1;
   logic        [COORD_WIDTH-2:0] range2;
   logic        [COORD_WIDTH-2:0] range3;

   modport source (
      output valid, anchor1_x, anchor1_y, anchor2_x, anchor2_y, anchor3_x, anchor3_y,
      output range1, range2, range3,
      input  ready
   );
   modport sink (
      input  valid, anchor1_x, anchor1_y, anchor2_x, anchor2_y, anchor3_x, anchor3_y,
      input  range1, range2, range3,
      output ready
   );
endinterface

interface tri_rsp_if #(parameter int COORD_WIDTH = 16) ();
   logic                                valid;
   logic                                ready;
   logic signed [COORD_WIDTH-1:0]       pos_x;
   logic signed [COORD_WIDTH-1:0]       pos_y;
   logic [tri_pkg::STATUS_WIDTH-1:0]    status;

   modport source (output valid, pos_x, pos_y, status, input ready);
   modport sink   (input valid, pos_x, pos_y, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tri_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tri_mul: two-stage signed multiplier
// Splits operand b in two halves, registers both partial products, then sums.
// ---------------------------------------------------------------------------
module tri_mul #(
   parameter  int A_W  = 17,
   parameter  int B_W  = 35,
   localparam int LO_W = B_W / 2,
   localparam int HI_W = B_W - LO_W,
   localparam int P_W  = A_W + B_W
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [A_W-1:0] a,
   input  logic signed [B_W-1:0] b,
   output logic signed [P_W-1:0] p
);

   logic signed [A_W+LO_W:0]   lo_ff;
   logic signed [A_W+HI_W-1:0] hi_ff;
   logic signed [P_W-1:0]      p_ff;

   // partial products, then shifted sum
   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= a * $signed({1'b0, b[LO_W-1:0]});
         hi_ff <= a * $signed(b[B_W-1:LO_W]);
         p_ff  <= (P_W'(hi_ff) <<< LO_W) + P_W'(lo_ff);
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tri_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tri_front: geometry front end
// Builds the exact numerators and denominator of the closed-form solution,
// takes magnitudes and flags degenerate anchors and quotient overflow.
// ---------------------------------------------------------------------------
module tri_front #(
   parameter  int COORD_WIDTH = 16,
   localparam int W   = COORD_WIDTH,
   localparam int WD  = W + 1,
   localparam int WP1 = 2 * WD,
   localparam int WS  = 2 * WD + 1,
   localparam int WP  = 2 * WS,
   localparam int WN  = WD + WP + 2,
   localparam int WM  = WP + 1,
   localparam int QB  = W + 3,
   localparam int NST = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [W-1:0]  a1x,
   input  logic signed [W-1:0]  a1y,
   input  logic signed [W-1:0]  a2x,
   input  logic signed [W-1:0]  a2y,
   input  logic signed [W-1:0]  a3x,
   input  logic signed [W-1:0]  a3y,
   input  logic [W-2:0]         r1,
   input  logic [W-2:0]         r2,
   input  logic [W-2:0]         r3,
   output logic                 out_valid,
   output logic [WN-1:0]        mag_x,
   output logic [WN-1:0]        mag_y,
   output logic                 neg_x,
   output logic                 neg_y,
   output logic                 ovf_x,
   output logic                 ovf_y,
   output logic [WM-1:0]        den_mag,
   output logic signed [W-1:0]  base_x,
   output logic signed [W-1:0]  base_y,
   output tri_pkg::tri_flags_type flags
);
   import tri_pkg::*;

   logic [NST-1:0] valid_ff;

   // stage 0: differences
   logic signed [WD-1:0] dx0_ff, dy0_ff, ax0_ff, ay0_ff;
   logic [W-2:0]         r1_ff, r2_ff, r3_ff;
   logic signed [W-1:0]  base_x_ff [NST];
   logic signed [W-1:0]  base_y_ff [NST];
   // stage 1: products
   logic signed [WP1-1:0] pdxdx_ff, pdydy_ff, pdxay_ff, pdyax_ff;
   logic signed [WP1-1:0] pdxax_ff, pdyay_ff, paxax_ff, payay_ff;
   logic [2*W-3:0]        s1_ff, s2_ff, s3_ff;
   logic signed [WD-1:0]  dx1_ff, dy1_ff;
   // stage 2: sums
   logic signed [WS-1:0]  d2_in, c_in, k_in, dot_in, a2_in, e_in;
   logic signed [WS-1:0]  s1w, s2w, s3w;
   logic signed [WS-1:0]  d2_ff, c_ff, k_ff, dot_ff, e_ff;
   logic signed [WD-1:0]  dx2_ff, dy2_ff;
   tri_flags_type         flags_ff [NST-2];
   // stages 3..4: first multiplier level
   logic signed [WP-1:0]    ed2_w, dotk_w, cd2_w;
   logic signed [WD+WS-1:0] dxk_w, dyk_w;
   logic signed [WS-1:0]    c3_ff, c4_ff;
   logic signed [WD-1:0]    dx3_ff, dy3_ff, dx4_ff, dy4_ff;
   // stage 5
   logic signed [WP:0]      m5_ff;
   logic signed [WD+WS-1:0] dxk5_ff, dyk5_ff;
   logic signed [WS-1:0]    c5_ff;
   logic signed [WD-1:0]    dx5_ff, dy5_ff;
   logic signed [WP-1:0]    cd2_5_ff, cd2_6_ff, cd2_7_ff;
   // stages 6..7: second multiplier level
   logic signed [WD+WP-1:0] dxkc_w, dykc_w;
   logic signed [WD+WP:0]   dym_w, dxm_w;
   // stage 8: numerators
   logic signed [WN-1:0] nx8_ff, ny8_ff;
   logic signed [WM-1:0] den8_ff;
   // stage 9: magnitudes
   logic [WN-1:0] magx9_ff, magy9_ff;
   logic [WM-1:0] den9_ff;
   logic          negx9_ff, negy9_ff;
   // stage 10: overflow check
   logic [WN-1:0] magx10_ff, magy10_ff;
   logic [WM-1:0] den10_ff;
   logic          negx10_ff, negy10_ff, ovfx10_ff, ovfy10_ff;

   // beat tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NST-2:0], in_valid};
      end
   end

   // anchor 1 and flags delay lines
   always_ff @(posedge clock) begin
      if (en) begin
         base_x_ff[0] <= a1x;
         base_y_ff[0] <= a1y;
         for (int i = 1; i < NST; i++) begin
            base_x_ff[i] <= base_x_ff[i-1];
            base_y_ff[i] <= base_y_ff[i-1];
         end
         flags_ff[0] <= '{coincide: (d2_in == '0), collinear: (c_in == '0)};
         for (int i = 1; i < NST - 2; i++) begin
            flags_ff[i] <= flags_ff[i-1];
         end
      end
   end

   // stage 0: offsets from anchor 1
   always_ff @(posedge clock) begin
      if (en) begin
         dx0_ff <= WD'(a2x) - WD'(a1x);
         dy0_ff <= WD'(a2y) - WD'(a1y);
         ax0_ff <= WD'(a3x) - WD'(a1x);
         ay0_ff <= WD'(a3y) - WD'(a1y);
         r1_ff  <= r1;
         r2_ff  <= r2;
         r3_ff  <= r3;
      end
   end

   // stage 1: small products
   always_ff @(posedge clock) begin
      if (en) begin
         pdxdx_ff <= dx0_ff * dx0_ff;
         pdydy_ff <= dy0_ff * dy0_ff;
         pdxay_ff <= dx0_ff * ay0_ff;
         pdyax_ff <= dy0_ff * ax0_ff;
         pdxax_ff <= dx0_ff * ax0_ff;
         pdyay_ff <= dy0_ff * ay0_ff;
         paxax_ff <= ax0_ff * ax0_ff;
         payay_ff <= ay0_ff * ay0_ff;
         s1_ff    <= r1_ff * r1_ff;
         s2_ff    <= r2_ff * r2_ff;
         s3_ff    <= r3_ff * r3_ff;
         dx1_ff   <= dx0_ff;
         dy1_ff   <= dy0_ff;
      end
   end

   // stage 2: squared distance, cross product and the k, dot, e terms
   always_comb begin
      s1w    = $signed(WS'(s1_ff));
      s2w    = $signed(WS'(s2_ff));
      s3w    = $signed(WS'(s3_ff));
      d2_in  = WS'(pdxdx_ff) + WS'(pdydy_ff);
      c_in   = WS'(pdxay_ff) - WS'(pdyax_ff);
      k_in   = s1w - s2w + d2_in;
      dot_in = WS'(pdxax_ff) + WS'(pdyay_ff);
      a2_in  = WS'(paxax_ff) + WS'(payay_ff);
      e_in   = s1w - s3w + a2_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff  <= d2_in;
         c_ff   <= c_in;
         k_ff   <= k_in;
         dot_ff <= dot_in;
         e_ff   <= e_in;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
      end
   end

   // first multiplier level
   tri_mul #(.A_W(WS), .B_W(WS)) u_mul_ed2 (
      .clock(clock), .en(en), .a(e_ff), .b(d2_ff), .p(ed2_w));
   tri_mul #(.A_W(WS), .B_W(WS)) u_mul_dotk (
      .clock(clock), .en(en), .a(dot_ff), .b(k_ff), .p(dotk_w));
   tri_mul #(.A_W(WS), .B_W(WS)) u_mul_cd2 (
      .clock(clock), .en(en), .a(c_ff), .b(d2_ff), .p(cd2_w));
   tri_mul #(.A_W(WD), .B_W(WS)) u_mul_dxk (
      .clock(clock), .en(en), .a(dx2_ff), .b(k_ff), .p(dxk_w));
   tri_mul #(.A_W(WD), .B_W(WS)) u_mul_dyk (
      .clock(clock), .en(en), .a(dy2_ff), .b(k_ff), .p(dyk_w));

   // operands waiting on the first level, then m = e*d2 - dot*k
   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff    <= c_ff;
         c4_ff    <= c3_ff;
         dx3_ff   <= dx2_ff;
         dy3_ff   <= dy2_ff;
         dx4_ff   <= dx3_ff;
         dy4_ff   <= dy3_ff;
         m5_ff    <= (WP+1)'(ed2_w) - (WP+1)'(dotk_w);
         dxk5_ff  <= dxk_w;
         dyk5_ff  <= dyk_w;
         c5_ff    <= c4_ff;
         dx5_ff   <= dx4_ff;
         dy5_ff   <= dy4_ff;
         cd2_5_ff <= cd2_w;
         cd2_6_ff <= cd2_5_ff;
         cd2_7_ff <= cd2_6_ff;
      end
   end

   // second multiplier level
   tri_mul #(.A_W(WD+WS), .B_W(WS)) u_mul_dxkc (
      .clock(clock), .en(en), .a(dxk5_ff), .b(c5_ff), .p(dxkc_w));
   tri_mul #(.A_W(WD+WS), .B_W(WS)) u_mul_dykc (
      .clock(clock), .en(en), .a(dyk5_ff), .b(c5_ff), .p(dykc_w));
   tri_mul #(.A_W(WD), .B_W(WP+1)) u_mul_dym (
      .clock(clock), .en(en), .a(dy5_ff), .b(m5_ff), .p(dym_w));
   tri_mul #(.A_W(WD), .B_W(WP+1)) u_mul_dxm (
      .clock(clock), .en(en), .a(dx5_ff), .b(m5_ff), .p(dxm_w));

   // numerators, denominator, magnitudes and the overflow compare
   always_ff @(posedge clock) begin
      if (en) begin
         nx8_ff    <= WN'(dxkc_w) - WN'(dym_w);
         ny8_ff    <= WN'(dykc_w) + WN'(dxm_w);
         den8_ff   <= WM'(cd2_7_ff) <<< 1;

         negx9_ff  <= nx8_ff[WN-1] ^ den8_ff[WM-1];
         negy9_ff  <= ny8_ff[WN-1] ^ den8_ff[WM-1];
         magx9_ff  <= nx8_ff[WN-1] ? WN'(-nx8_ff) : WN'(nx8_ff);
         magy9_ff  <= ny8_ff[WN-1] ? WN'(-ny8_ff) : WN'(ny8_ff);
         den9_ff   <= den8_ff[WM-1] ? WM'(-den8_ff) : WM'(den8_ff);

         magx10_ff <= magx9_ff;
         magy10_ff <= magy9_ff;
         den10_ff  <= den9_ff;
         negx10_ff <= negx9_ff;
         negy10_ff <= negy9_ff;
         ovfx10_ff <= (WN+1)'(magx9_ff) >= ((WN+1)'(den9_ff) << QB);
         ovfy10_ff <= (WN+1)'(magy9_ff) >= ((WN+1)'(den9_ff) << QB);
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign mag_x     = magx10_ff;
   assign mag_y     = magy10_ff;
   assign neg_x     = negx10_ff;
   assign neg_y     = negy10_ff;
   assign ovf_x     = ovfx10_ff;
   assign ovf_y     = ovfy10_ff;
   assign den_mag   = den10_ff;
   assign base_x    = base_x_ff[NST-1];
   assign base_y    = base_y_ff[NST-1];
   assign flags     = flags_ff[NST-3];

endmodule
`default_nettype wire

// ===== rtl/core/tri_div_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tri_div_cell: one restoring division step
// Resolves one quotient bit for both coordinates and hands the partial
// remainders and side data to the next cell.
// ---------------------------------------------------------------------------
module tri_div_cell #(
   parameter  int REM_W  = 90,
   parameter  int DEN_W  = 71,
   parameter  int Q_W    = 19,
   parameter  int BIT    = 0,
   parameter  int SIDE_W = 38,
   localparam int SW     = REM_W + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_i,
   input  logic [REM_W-1:0]  rem_x_i,
   input  logic [REM_W-1:0]  rem_y_i,
   input  logic [DEN_W-1:0]  den_i,
   input  logic [Q_W-1:0]    q_x_i,
   input  logic [Q_W-1:0]    q_y_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              valid_o,
   output logic [REM_W-1:0]  rem_x_o,
   output logic [REM_W-1:0]  rem_y_o,
   output logic [DEN_W-1:0]  den_o,
   output logic [Q_W-1:0]    q_x_o,
   output logic [Q_W-1:0]    q_y_o,
   output logic [SIDE_W-1:0] side_o
);

   logic [SW-1:0]    den_sh;
   logic [SW-1:0]    trial_x, trial_y;
   logic             valid_ff;
   logic [REM_W-1:0] rem_x_ff, rem_y_ff;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   q_x_ff, q_y_ff;
   logic [SIDE_W-1:0] side_ff;

   // trial subtract of the aligned divisor
   always_comb begin
      den_sh  = SW'(den_i) << BIT;
      trial_x = SW'(rem_x_i) - den_sh;
      trial_y = SW'(rem_y_i) - den_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   // keep or restore, set the quotient bit
   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff <= trial_x[SW-1] ? rem_x_i : trial_x[REM_W-1:0];
         rem_y_ff <= trial_y[SW-1] ? rem_y_i : trial_y[REM_W-1:0];
         q_x_ff   <= trial_x[SW-1] ? q_x_i : (q_x_i | (Q_W'(1) << BIT));
         q_y_ff   <= trial_y[SW-1] ? q_y_i : (q_y_i | (Q_W'(1) << BIT));
         den_ff   <= den_i;
         side_ff  <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_x_o = rem_x_ff;
   assign rem_y_o = rem_y_ff;
   assign den_o   = den_ff;
   assign q_x_o   = q_x_ff;
   assign q_y_o   = q_y_ff;
   assign side_o  = side_ff;

endmodule
`default_nettype wire

// ===== rtl/core/trilateration_2d.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trilateration_2d: three-anchor 2D position solver
// Exact closed-form trilateration with one rounding, saturation and status.
// ---------------------------------------------------------------------------
// Structure: 11 front-end stages, COORD_WIDTH + 3 division cells, one rounding stage,
//   one output register.
// Throughput: one beat per cycle unless a held response stalls it; the division cell chain is fully pipelined.
// A held response freezes the whole pipeline until it is taken.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
module trilateration_2d #(
   parameter int COORD_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   tri_req_if.sink    req,
   tri_rsp_if.source  rsp
);
   import tri_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int WD     = W + 1;
   localparam int WS     = 2 * WD + 1;
   localparam int WP     = 2 * WS;
   localparam int WN     = WD + WP + 2;
   localparam int WM     = WP + 1;
   localparam int QB     = W + 3;
   localparam int REM_W  = WN + 1;
   localparam int SIDE_W = 2 * W + 6;
   localparam int TW     = QB + 3;

   localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] POS_MIN = {1'b1, {(W-1){1'b0}}};

   logic en;

   logic                fr_valid;
   logic [WN-1:0]       fr_mag_x, fr_mag_y;
   logic                fr_neg_x, fr_neg_y, fr_ovf_x, fr_ovf_y;
   logic [WM-1:0]       fr_den;
   logic signed [W-1:0] fr_base_x, fr_base_y;
   tri_flags_type       fr_flags;

   logic              cv    [QB+1];
   logic [REM_W-1:0]  crx   [QB+1];
   logic [REM_W-1:0]  cry   [QB+1];
   logic [WM-1:0]     cden  [QB+1];
   logic [QB-1:0]     cqx   [QB+1];
   logic [QB-1:0]     cqy   [QB+1];
   logic [SIDE_W-1:0] cside [QB+1];

   logic                cd_neg_x, cd_neg_y, cd_ovf_x, cd_ovf_y;
   tri_flags_type       cd_flags;
   logic signed [W-1:0] cd_base_x, cd_base_y;

   logic                rd_valid_ff;
   logic [QB:0]         rq_x_ff, rq_y_ff;
   logic                rd_neg_x_ff, rd_neg_y_ff, rd_ovf_x_ff, rd_ovf_y_ff;
   tri_flags_type       rd_flags_ff;
   logic signed [W-1:0] rd_base_x_ff, rd_base_y_ff;

   logic signed [QB+1:0] off_x, off_y;
   logic signed [TW-1:0] t_x, t_y;
   logic signed [W-1:0]  px_in, py_in;
   logic                 sat_x, sat_y;
   tri_status_type       status_in;

   logic                 rsp_valid_ff;
   logic signed [W-1:0]  pos_x_ff, pos_y_ff;
   tri_status_type       status_ff;

   // the pipeline moves whenever the output register is free or being read
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   tri_front #(.COORD_WIDTH(W)) u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req.valid),
      .a1x(req.anchor1_x), .a1y(req.anchor1_y),
      .a2x(req.anchor2_x), .a2y(req.anchor2_y),
      .a3x(req.anchor3_x), .a3y(req.anchor3_y),
      .r1(req.range1), .r2(req.range2), .r3(req.range3),
      .out_valid(fr_valid), .mag_x(fr_mag_x), .mag_y(fr_mag_y),
      .neg_x(fr_neg_x), .neg_y(fr_neg_y), .ovf_x(fr_ovf_x), .ovf_y(fr_ovf_y),
      .den_mag(fr_den), .base_x(fr_base_x), .base_y(fr_base_y), .flags(fr_flags)
   );

   // head of the division chain
   assign cv[0]    = fr_valid;
   assign crx[0]   = REM_W'(fr_mag_x);
   assign cry[0]   = REM_W'(fr_mag_y);
   assign cden[0]  = fr_den;
   assign cqx[0]   = '0;
   assign cqy[0]   = '0;
   assign cside[0] = {fr_neg_x, fr_neg_y, fr_ovf_x, fr_ovf_y, fr_flags, fr_base_x, fr_base_y};

   // one cell per quotient bit, most significant first
   for (genvar i = 0; i < QB; i++) begin : g_cell
      tri_div_cell #(
         .REM_W(REM_W), .DEN_W(WM), .Q_W(QB), .BIT(QB - 1 - i), .SIDE_W(SIDE_W)
      ) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .valid_i(cv[i]), .rem_x_i(crx[i]), .rem_y_i(cry[i]), .den_i(cden[i]),
         .q_x_i(cqx[i]), .q_y_i(cqy[i]), .side_i(cside[i]),
         .valid_o(cv[i+1]), .rem_x_o(crx[i+1]), .rem_y_o(cry[i+1]),
         .den_o(cden[i+1]), .q_x_o(cqx[i+1]), .q_y_o(cqy[i+1]), .side_o(cside[i+1])
      );
   end

   assign {cd_neg_x, cd_neg_y, cd_ovf_x, cd_ovf_y, cd_flags, cd_base_x, cd_base_y} = cside[QB];

   // rounding stage: half up on the magnitude gives ties away from zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (en) begin
         rd_valid_ff <= cv[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rq_x_ff <= (QB+1)'(cqx[QB])
                  + (QB+1)'({crx[QB], 1'b0} >= (REM_W+1)'(cden[QB]));
         rq_y_ff <= (QB+1)'(cqy[QB])
                  + (QB+1)'({cry[QB], 1'b0} >= (REM_W+1)'(cden[QB]));
         rd_neg_x_ff  <= cd_neg_x;
         rd_neg_y_ff  <= cd_neg_y;
         rd_ovf_x_ff  <= cd_ovf_x;
         rd_ovf_y_ff  <= cd_ovf_y;
         rd_flags_ff  <= cd_flags;
         rd_base_x_ff <= cd_base_x;
         rd_base_y_ff <= cd_base_y;
      end
   end

   // add anchor 1, clamp, and pick the status
   always_comb begin
      off_x = rd_neg_x_ff ? -$signed({1'b0, rq_x_ff}) : $signed({1'b0, rq_x_ff});
      off_y = rd_neg_y_ff ? -$signed({1'b0, rq_y_ff}) : $signed({1'b0, rq_y_ff});
      t_x   = TW'(rd_base_x_ff) + TW'(off_x);
      t_y   = TW'(rd_base_y_ff) + TW'(off_y);

      sat_x = 1'b1;
      if (rd_ovf_x_ff) begin
         px_in = rd_neg_x_ff ? POS_MIN : POS_MAX;
      end else if (t_x > TW'(POS_MAX)) begin
         px_in = POS_MAX;
      end else if (t_x < TW'(POS_MIN)) begin
         px_in = POS_MIN;
      end else begin
         px_in = t_x[W-1:0];
         sat_x = 1'b0;
      end

      sat_y = 1'b1;
      if (rd_ovf_y_ff) begin
         py_in = rd_neg_y_ff ? POS_MIN : POS_MAX;
      end else if (t_y > TW'(POS_MAX)) begin
         py_in = POS_MAX;
      end else if (t_y < TW'(POS_MIN)) begin
         py_in = POS_MIN;
      end else begin
         py_in = t_y[W-1:0];
         sat_y = 1'b0;
      end

      status_in = (sat_x || sat_y) ? STATUS_SAT : STATUS_OK;
      if (rd_flags_ff.coincide) begin
         px_in     = '0;
         py_in     = '0;
         status_in = STATUS_COINCIDE;
      end else if (rd_flags_ff.collinear) begin
         px_in     = '0;
         py_in     = '0;
         status_in = STATUS_COLLINEAR;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff  <= px_in;
         pos_y_ff  <= py_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.pos_x  = pos_x_ff;
   assign rsp.pos_y  = pos_y_ff;
   assign rsp.status = status_ff;

   // degenerate anchors always report the origin
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STATUS_COINCIDE || status_ff == STATUS_COLLINEAR))
      |-> (pos_x_ff == '0 && pos_y_ff == '0))
      else $error("degenerate status with non-zero position");

   // a saturated beat has a coordinate on a bound
   a_sat_on_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_SAT)
      |-> (pos_x_ff == POS_MAX || pos_x_ff == POS_MIN
           || pos_y_ff == POS_MAX || pos_y_ff == POS_MIN))
      else $error("saturated status without a clamped coordinate");

   // a stalled pipeline does not accept a beat
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("request taken while the pipeline is stalled");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule
`default_nettype wire
